// ===== rtl/quaternary_min_heap_queue_defines.svh =====
// assertion macros for the quaternary min-heap queue
`ifndef QUATERNARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define QUATERNARY_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, checked on clk with reset masking
`define QMHQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masking
`define QMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qmhq_pkg.sv =====
// types, codes and constants of the quaternary min-heap queue
`default_nettype none

package qmhq_pkg;

    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_NODE_BITS = 16;

    localparam int ARITY      = 4;
    localparam int ARITY_LOG2 = 2;
    localparam int CH_W       = 3;

    localparam int F_W     = 32;
    localparam int G_W     = 32;
    localparam int NODE_W  = 16;
    localparam int COUNT_W = 11;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] node_id;
        logic [F_W-1:0]    f_score;
        logic [G_W-1:0]    g_score;
    } in_item_t;

    typedef struct packed {
        logic               out_valid;
        logic [NODE_W-1:0]  out_node;
        logic               overflow;
        logic [COUNT_W-1:0] item_count;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_INS_CMP,
        ST_REM_TOP,
        ST_REM_LAST,
        ST_REM_MOVE,
        ST_DN_SCAN,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/quaternary_min_heap_queue.sv =====
// 4-ary min-heap priority queue with one shared key comparator and a single-port heap memory
`default_nettype none
`include "quaternary_min_heap_queue_defines.svh"

// Open-list priority queue for path search. Each transaction is an insert, a remove of the
// least entry, or a clear, and the unused function code is a no-op; each gives exactly one
// result transaction with the popped handle, an overflow flag for an insert into a full heap,
// and the entry count afterwards. Keys are compared f first, then g when the tie bit is set
// (cfg_wdata under cfg_we, set at reset; insert lets a larger g climb past an equal f, remove
// descends to the child with the smaller g). The heap lives in one memory with one write or
// one registered read per cycle, and one comparator serves every step, so the block takes one
// transaction at a time. An insert reads the parent, compares and writes at each level it
// climbs; a remove reads the root, reads the last entry, then at each level reads the children
// with the reads overlapped with the compares and writes the best child up into the hole. A
// 1024-entry heap has 5 levels below the root. The result sits in an output register, so a
// stalled result only holds the next transaction at its end.
module quaternary_min_heap_queue #(
    parameter int CAPACITY  = qmhq_pkg::DEF_CAPACITY,
    parameter int NODE_BITS = qmhq_pkg::DEF_NODE_BITS
) (
    input  wire                logic      clk,
    input  wire                logic      rst_n,
    input  wire                logic      cfg_we,
    input  wire                logic      cfg_wdata,
    input  wire                logic      in_valid,
    output                     logic      in_stall,
    input  wire qmhq_pkg::in_item_t       in_data,
    output                     logic      res_valid,
    input  wire                logic      res_stall,
    output qmhq_pkg::res_item_t           res_data
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CIW   = AW + 3;
    localparam int ENT_W = qmhq_pkg::F_W + qmhq_pkg::G_W + NODE_BITS;
    localparam int FW    = qmhq_pkg::F_W;
    localparam int GW    = qmhq_pkg::G_W;

    qmhq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [qmhq_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic                         cmp_pend_reg, cmp_pend_next;
    logic [AW-1:0]                rd_idx_reg, rd_idx_next;
    logic [FW-1:0]                best_f_reg, best_f_next;
    logic [GW-1:0]                best_g_reg, best_g_next;
    logic [NODE_BITS-1:0]         best_node_reg, best_node_next;
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic [FW-1:0]                item_f_reg, item_f_next;
    logic [GW-1:0]                item_g_reg, item_g_next;
    logic [NODE_BITS-1:0]         item_node_reg, item_node_next;
    logic [NODE_BITS-1:0]         top_node_reg, top_node_next;
    logic                         pop_reg, pop_next;
    logic                         ovf_reg, ovf_next;
    logic                         tie_reg;
    logic                         res_valid_reg, res_valid_next;
    qmhq_pkg::res_item_t          res_data_reg, res_data_next;

    logic [ENT_W-1:0] heap_mem [CAPACITY];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    logic [FW-1:0]        rd_f;
    logic [GW-1:0]        rd_g;
    logic [NODE_BITS-1:0] rd_node;
    logic [CIW-1:0]       child_idx;
    logic [AW-1:0]        par_idx;
    logic [31:0]          in_node32;
    logic [31:0]          top32;
    logic [31:0]          cnt32;

    // shared comparator operands
    logic [FW-1:0] cmp_af, cmp_bf;
    logic [GW-1:0] cmp_ga, cmp_gb;
    logic          cmp_better;

    assign rd_f    = rd_data_reg[ENT_W-1 -: FW];
    assign rd_g    = rd_data_reg[NODE_BITS +: GW];
    assign rd_node = rd_data_reg[NODE_BITS-1:0];

    assign child_idx = (CIW'(pos_reg) << qmhq_pkg::ARITY_LOG2) + CIW'(ch_reg) + CIW'(1);
    assign par_idx   = AW'((pos_reg - AW'(1)) >> qmhq_pkg::ARITY_LOG2);
    assign in_node32 = 32'(in_data.node_id);
    assign top32     = 32'(top_node_reg);
    assign cnt32     = 32'(count_next);

    // insert: new entry vs parent; remove: child vs current best
    always_comb
    begin
        if (state_reg == qmhq_pkg::ST_INS_CMP)
        begin
            cmp_af = item_f_reg;
            cmp_bf = rd_f;
            cmp_ga = item_g_reg;
            cmp_gb = rd_g;
        end
        else
        begin
            cmp_af = rd_f;
            cmp_bf = best_f_reg;
            cmp_ga = best_g_reg;
            cmp_gb = rd_g;
        end
    end

    assign cmp_better = (cmp_af < cmp_bf) || (tie_reg && (cmp_af == cmp_bf) && (cmp_ga > cmp_gb));

    assign in_stall  = (state_reg != qmhq_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        logic rd_go;

        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        cmp_pend_next  = cmp_pend_reg;
        rd_idx_next    = rd_idx_reg;
        best_f_next    = best_f_reg;
        best_g_next    = best_g_reg;
        best_node_next = best_node_reg;
        best_idx_next  = best_idx_reg;
        item_f_next    = item_f_reg;
        item_g_next    = item_g_reg;
        item_node_next = item_node_reg;
        top_node_next  = top_node_reg;
        pop_next       = pop_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;
        rd_go          = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            qmhq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_f_next    = in_data.f_score;
                    item_g_next    = in_data.g_score;
                    item_node_next = in_node32[NODE_BITS-1:0];
                    pop_next       = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = qmhq_pkg::ST_FIN;
                    case (in_data.func)
                        qmhq_pkg::FUNC_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                pos_next   = AW'(count_reg);
                                state_next = qmhq_pkg::ST_INS_STEP;
                            end
                        end
                        qmhq_pkg::FUNC_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                pop_next   = 1'b1;
                                state_next = qmhq_pkg::ST_REM_TOP;
                            end
                        end
                        qmhq_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = qmhq_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            qmhq_pkg::ST_INS_STEP:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = {item_f_reg, item_g_reg, item_node_reg};
                    count_next = count_reg + CW'(1);
                    state_next = qmhq_pkg::ST_FIN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = par_idx;
                    state_next = qmhq_pkg::ST_INS_CMP;
                end
            end

            qmhq_pkg::ST_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (cmp_better)
                begin
                    // parent moves down into the hole
                    mem_wdata  = rd_data_reg;
                    pos_next   = par_idx;
                    state_next = qmhq_pkg::ST_INS_STEP;
                end
                else
                begin
                    mem_wdata  = {item_f_reg, item_g_reg, item_node_reg};
                    count_next = count_reg + CW'(1);
                    state_next = qmhq_pkg::ST_FIN;
                end
            end

            qmhq_pkg::ST_REM_TOP:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = qmhq_pkg::ST_REM_LAST;
            end

            qmhq_pkg::ST_REM_LAST:
            begin
                top_node_next = rd_node;
                mem_re        = 1'b1;
                mem_raddr     = AW'(count_reg - CW'(1));
                state_next    = qmhq_pkg::ST_REM_MOVE;
            end

            qmhq_pkg::ST_REM_MOVE:
            begin
                item_f_next    = rd_f;
                item_g_next    = rd_g;
                item_node_next = rd_node;
                best_f_next    = rd_f;
                best_g_next    = rd_g;
                best_node_next = rd_node;
                best_idx_next  = '0;
                pos_next       = '0;
                ch_next        = '0;
                cmp_pend_next  = 1'b0;
                count_next     = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = qmhq_pkg::ST_FIN;
                end
                else
                begin
                    state_next = qmhq_pkg::ST_DN_SCAN;
                end
            end

            qmhq_pkg::ST_DN_SCAN:
            begin
                // read the next child while the previous one is compared
                rd_go = (ch_reg < qmhq_pkg::CH_W'(qmhq_pkg::ARITY))
                        && (child_idx < CIW'(count_reg));
                if (cmp_pend_reg && cmp_better)
                begin
                    best_f_next    = rd_f;
                    best_g_next    = rd_g;
                    best_node_next = rd_node;
                    best_idx_next  = rd_idx_reg;
                end
                if (rd_go)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = child_idx[AW-1:0];
                    rd_idx_next   = child_idx[AW-1:0];
                    ch_next       = ch_reg + qmhq_pkg::CH_W'(1);
                    cmp_pend_next = 1'b1;
                end
                else if (cmp_pend_reg)
                begin
                    cmp_pend_next = 1'b0;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    if (best_idx_reg == pos_reg)
                    begin
                        mem_wdata  = {item_f_reg, item_g_reg, item_node_reg};
                        state_next = qmhq_pkg::ST_FIN;
                    end
                    else
                    begin
                        // best child moves up, hole goes down one level
                        mem_wdata      = {best_f_reg, best_g_reg, best_node_reg};
                        pos_next       = best_idx_reg;
                        ch_next        = '0;
                        best_f_next    = item_f_reg;
                        best_g_next    = item_g_reg;
                        best_node_next = item_node_reg;
                    end
                end
            end

            qmhq_pkg::ST_FIN:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next           = 1'b1;
                    res_data_next.out_valid  = pop_reg;
                    res_data_next.out_node   = pop_reg ? top32[qmhq_pkg::NODE_W-1:0] : '0;
                    res_data_next.overflow   = ovf_reg;
                    res_data_next.item_count = cnt32[qmhq_pkg::COUNT_W-1:0];
                    state_next               = qmhq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = qmhq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qmhq_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_pend_reg  <= 1'b0;
            pop_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            tie_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_pend_reg  <= cmp_pend_next;
            pop_reg       <= pop_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                tie_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        ch_reg        <= ch_next;
        rd_idx_reg    <= rd_idx_next;
        best_f_reg    <= best_f_next;
        best_g_reg    <= best_g_next;
        best_node_reg <= best_node_next;
        best_idx_reg  <= best_idx_next;
        item_f_reg    <= item_f_next;
        item_g_reg    <= item_g_next;
        item_node_reg <= item_node_next;
        top_node_reg  <= top_node_next;
        res_data_reg  <= res_data_next;
    end

    // heap storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= heap_mem[mem_raddr];
        end
    end

    `QMHQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `QMHQ_ASSERT_SAME(a_ovf_full, state_reg == qmhq_pkg::ST_FIN && ovf_reg, count_reg == CW'(CAPACITY), "overflow with room left")
    `QMHQ_ASSERT_SAME(a_pop_no_ovf, res_valid_reg && res_data_reg.out_valid, !res_data_reg.overflow, "pop and overflow in one transaction")
    `QMHQ_ASSERT_SAME(a_hole_in_heap, state_reg == qmhq_pkg::ST_DN_SCAN, pos_reg < AW'(count_reg) || CW'(pos_reg) < count_reg, "sift-down hole outside the heap")
    `QMHQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transaction taken while busy")
    `QMHQ_ASSERT_NEXT(a_clear_empties, in_valid && !in_stall && in_data.func == qmhq_pkg::FUNC_CLEAR, count_reg == '0, "clear left entries")

endmodule

`default_nettype wire
